@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check prop on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/clnp_pkg.sv @@
// ---------------------------------------------------------------------------
// clnp_pkg
// Types and constants shared by the circular list node pool.
// ---------------------------------------------------------------------------
`default_nettype none

package clnp_pkg;

  localparam int POOL_NODES = 16;
  localparam int TAG_W      = 16;
  localparam int SLOT_W     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int CNT_W      = $clog2(POOL_NODES + 1);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [TAG_W-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  list_length;
  } out_item_t;

  // Requests to the node allocator.
  typedef struct packed {
    logic              set;
    logic              clr;
    logic              clr_all;
    logic [SLOT_W-1:0] idx;
  } alloc_ctl_t;

  // Allocator view: used marks and lowest free node.
  typedef struct packed {
    logic [POOL_NODES-1:0] used;
    logic                  found;
    logic [SLOT_W-1:0]     free_idx;
  } alloc_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/circular_list_node_pool_core.sv @@
// ---------------------------------------------------------------------------
// circular_list_node_pool_core
// One circular singly linked list built over a fixed pool of nodes.
// ---------------------------------------------------------------------------
// Each input item is an insert, a delete or a clear, and yields exactly one
// result item (status, slot, list length). Node tags and next links live in
// two synchronous memories whose reads are registered; used marks sit in
// flip-flops, so reset and clear take effect at once and no clearing pass is
// needed. From acceptance, clear, pool-full insert, empty-list delete, the
// unused action code and insert into an empty list go straight to the done
// state, which moves the result into the output register; insert behind a
// tail first passes through a link state (the tail link write shares the link
// memory's single write port with the new node's link); delete first walks
// the list, visiting n nodes from the head (1 to 16). The walk visits one
// node per cycle: the registered link read out of the link memory drives the
// next read address. One item is in flight at a time; the next item is
// accepted as soon as the core is idle, even while the previous result still
// waits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_list_node_pool_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire clnp_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output clnp_pkg::out_item_t      out_item
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_LINK,
    S_WALK,
    S_DONE
  } state_t;

  localparam int SW = clnp_pkg::SLOT_W;
  localparam int CW = clnp_pkg::CNT_W;
  localparam int TW = clnp_pkg::TAG_W;

  // Control state
  state_t            state_r,   state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SW-1:0]     head_r,    head_nxt;
  logic [SW-1:0]     tail_r,    tail_nxt;
  logic              empty_r,   empty_nxt;
  logic [CW-1:0]     count_r,   count_nxt;

  // Payload and walk registers
  clnp_pkg::out_item_t out_item_r, out_item_nxt;
  clnp_pkg::out_item_t res_r,      res_nxt;
  logic [TW-1:0]     tag_r,     tag_nxt;
  logic [SW-1:0]     cur_r,     cur_nxt;
  logic [SW-1:0]     prev_r,    prev_nxt;
  logic [CW-1:0]     remain_r,  remain_nxt;

  // Node memories
  logic [TW-1:0]     tag_mem  [clnp_pkg::POOL_NODES];
  logic [SW-1:0]     link_mem [clnp_pkg::POOL_NODES];
  logic [TW-1:0]     tag_rd_r;
  logic [SW-1:0]     link_rd_r;
  logic              rd_en;
  logic [SW-1:0]     rd_addr;
  logic              tag_we;
  logic [SW-1:0]     tag_wa;
  logic [TW-1:0]     tag_wd;
  logic              link_we;
  logic [SW-1:0]     link_wa;
  logic [SW-1:0]     link_wd;

  clnp_pkg::alloc_ctl_t actl;
  clnp_pkg::alloc_sts_t asts;

  clnp_alloc u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (actl),
    .sts   (asts)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Reads happen only in delete walk cycles that write nothing, so the same
  // entry is never read and written in one cycle.
  always_ff @(posedge clk) begin
    if (tag_we)  tag_mem[tag_wa]   <= tag_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (rd_en) begin
      tag_rd_r  <= tag_mem[rd_addr];
      link_rd_r <= link_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    tag_nxt       = tag_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    remain_nxt    = remain_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    tag_we        = 1'b0;
    tag_wa        = '0;
    tag_wd        = '0;
    link_we       = 1'b0;
    link_wa       = '0;
    link_wd       = '0;
    actl          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tag_nxt     = in_item.tag;
          res_nxt     = '{status: clnp_pkg::ST_OK, slot: '0, list_length: count_r};
          state_nxt   = S_DONE;
          unique case (in_item.action)
            clnp_pkg::ACT_INSERT: begin
              if (!asts.found) begin
                res_nxt.status = clnp_pkg::ST_FULL;
              end else begin
                // Claim the lowest free node and write its tag and link.
                actl.set    = 1'b1;
                actl.idx    = asts.free_idx;
                tag_we      = 1'b1;
                tag_wa      = asts.free_idx;
                tag_wd      = in_item.tag;
                link_we     = 1'b1;
                link_wa     = asts.free_idx;
                link_wd     = empty_r ? asts.free_idx : head_r;
                count_nxt   = count_r + CW'(1);
                res_nxt.slot        = asts.free_idx;
                res_nxt.list_length = count_r + CW'(1);
                if (empty_r) begin
                  head_nxt  = asts.free_idx;
                  tail_nxt  = asts.free_idx;
                  empty_nxt = 1'b0;
                end else begin
                  cur_nxt   = asts.free_idx;
                  state_nxt = S_INS_LINK;
                end
              end
            end
            clnp_pkg::ACT_DELETE: begin
              if (empty_r) begin
                res_nxt.status = clnp_pkg::ST_MISS;
              end else begin
                // Start the walk at the head; the tail is its predecessor.
                rd_en      = 1'b1;
                rd_addr    = head_r;
                cur_nxt    = head_r;
                prev_nxt   = tail_r;
                remain_nxt = count_r;
                state_nxt  = S_WALK;
              end
            end
            clnp_pkg::ACT_CLEAR: begin
              actl.clr_all        = 1'b1;
              head_nxt            = '0;
              tail_nxt            = '0;
              empty_nxt           = 1'b1;
              count_nxt           = '0;
              res_nxt.list_length = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_INS_LINK: begin
        // Hook the new node behind the old tail.
        link_we   = 1'b1;
        link_wa   = tail_r;
        link_wd   = cur_r;
        tail_nxt  = cur_r;
        state_nxt = S_DONE;
      end

      S_WALK: begin
        if (tag_rd_r == tag_r) begin
          // Unlink and free the matching node.
          actl.clr  = 1'b1;
          actl.idx  = cur_r;
          count_nxt = count_r - CW'(1);
          res_nxt   = '{status: clnp_pkg::ST_OK, slot: cur_r,
                        list_length: count_r - CW'(1)};
          if (cur_r == head_r) begin
            if (head_r == tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              link_we  = 1'b1;
              link_wa  = tail_r;
              link_wd  = link_rd_r;
              head_nxt = link_rd_r;
            end
          end else begin
            link_we = 1'b1;
            link_wa = prev_r;
            link_wd = link_rd_r;
            if (cur_r == tail_r) tail_nxt = prev_r;
          end
          state_nxt = S_DONE;
        end else if (remain_r == CW'(1)) begin
          res_nxt   = '{status: clnp_pkg::ST_MISS, slot: '0, list_length: count_r};
          state_nxt = S_DONE;
        end else begin
          // Advance to the next node straight from the link just read.
          rd_en      = 1'b1;
          rd_addr    = link_rd_r;
          prev_nxt   = cur_r;
          cur_nxt    = link_rd_r;
          remain_nxt = remain_r - CW'(1);
        end
      end

      S_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      count_r     <= count_nxt;
    end
    out_item_r <= out_item_nxt;
    res_r      <= res_nxt;
    tag_r      <= tag_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    remain_r   <= remain_nxt;
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
`include "assert_macros.svh"

  `ASSERT_RST(a_empty_matches_count, empty_r == (count_r == '0), "empty flag and node count disagree")
  `ASSERT_RST(a_used_matches_count, $countones(asts.used) == 32'(count_r), "used marks and node count disagree")
  `ASSERT_RST(a_walk_on_used_node, (state_r == S_WALK) |-> asts.used[cur_r], "delete walk reached a free node")

endmodule

`default_nettype wire

@@ hw/rtl/clnp_alloc.sv @@
// ---------------------------------------------------------------------------
// clnp_alloc
// Used marks of the node pool and the lowest-free-node search.
// ---------------------------------------------------------------------------
`default_nettype none

module clnp_alloc (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire clnp_pkg::alloc_ctl_t ctl,
  output clnp_pkg::alloc_sts_t    sts
);

  logic [clnp_pkg::POOL_NODES-1:0] used_r;
  logic [clnp_pkg::POOL_NODES-1:0] used_nxt;
  logic                            found;
  logic [clnp_pkg::SLOT_W-1:0]     free_idx;

  always_comb begin
    used_nxt = used_r;
    if (ctl.clr_all) begin
      used_nxt = '0;
    end else begin
      if (ctl.set) used_nxt[ctl.idx] = 1'b1;
      if (ctl.clr) used_nxt[ctl.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // Scan from the top so the lowest free index wins.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = clnp_pkg::POOL_NODES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        found    = 1'b1;
        free_idx = clnp_pkg::SLOT_W'(i);
      end
    end
  end

  assign sts.used     = used_r;
  assign sts.found    = found;
  assign sts.free_idx = free_idx;

endmodule

`default_nettype wire
